FILE: src/assert_macros.svh
// Assertion helpers for the ALU unit; both sample on clk and stay quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sia_pkg.sv
package sia_pkg;

	localparam int DW      = 32;
	localparam int CMD_W   = 5;
	localparam int SHAMT_W = 5;
	localparam int IN_W    = ((CMD_W + 2 * DW + 7) / 8) * 8;
	localparam int OUT_W   = ((DW + 1 + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET = 5'd0,
		CMD_ADD = 5'd1,
		CMD_SUB = 5'd2,
		CMD_MUL = 5'd3,
		CMD_DIV = 5'd4,
		CMD_MOD = 5'd5,
		CMD_AND = 5'd6,
		CMD_OR  = 5'd7,
		CMD_XOR = 5'd8,
		CMD_EQ  = 5'd9,
		CMD_NE  = 5'd10,
		CMD_GT  = 5'd11,
		CMD_LT  = 5'd12,
		CMD_GE  = 5'd13,
		CMD_LE  = 5'd14,
		CMD_SHR = 5'd15,
		CMD_SHL = 5'd16
	} cmd_t;

	// Word carried down the divider pipe; non-divide results ride along in res.
	typedef struct packed {
		logic          sel_div;
		logic          sel_mod;
		logic          err;
		logic          q_neg;
		logic          r_neg;
		logic [DW-1:0] res;
		logic [DW-1:0] rem;
		logic [DW-1:0] dq;
		logic [DW-1:0] dvs;
	} div_word_t;

endpackage

FILE: src/signed_int32_alu_unit.sv
// Every command runs the whole pipe, from stage 1 through the divider stages and the output register, to m_tdata.
// Throughput: one word per cycle; a stall at the output backs up stage by stage, and
// empty stages keep taking words until the pipe is full.
// Reset: arst_n clears every stage valid bit and m_tvalid at once; data registers keep
// whatever they hold.
module signed_int32_alu_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [4:0] command, [36:5] left_operand, [68:37] right_operand, [71:69] zero
	input  logic [sia_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [31:0] result_value, [32] error_code, [39:33] zero
	output logic [sia_pkg::OUT_W-1:0] m_tdata
);
	import sia_pkg::*;

	// Unpack the input word.
	cmd_t            cmd;
	logic [DW-1:0]   opa;
	logic [DW-1:0]   opb;
	logic [SHAMT_W-1:0] amt;

	assign cmd = cmd_t'(s_tdata[CMD_W-1:0]);
	assign opa = s_tdata[CMD_W +: DW];
	assign opb = s_tdata[CMD_W + DW +: DW];
	assign amt = opb[SHAMT_W-1:0];

	// Stage 1: everything except the divide, plus operand magnitudes for the divider.
	logic [DW-1:0]   prod;
	logic [DW-1:0]   simple_res;
	logic            is_divmod;
	logic            div_zero;
	div_word_t       word_in;

	// Only the low half of the product is kept; it wraps the same for signed operands.
	assign prod = opa * opb;

	always_comb begin
		case (cmd)
			CMD_SET: simple_res = opb;
			CMD_ADD: simple_res = opa + opb;
			CMD_SUB: simple_res = opa - opb;
			CMD_MUL: simple_res = prod;
			CMD_AND: simple_res = opa & opb;
			CMD_OR:  simple_res = opa | opb;
			CMD_XOR: simple_res = opa ^ opb;
			CMD_EQ:  simple_res = {{(DW-1){1'b0}}, (opa == opb)};
			CMD_NE:  simple_res = {{(DW-1){1'b0}}, (opa != opb)};
			CMD_GT:  simple_res = {{(DW-1){1'b0}}, ($signed(opa) > $signed(opb))};
			CMD_LT:  simple_res = {{(DW-1){1'b0}}, ($signed(opa) < $signed(opb))};
			CMD_GE:  simple_res = {{(DW-1){1'b0}}, ($signed(opa) >= $signed(opb))};
			CMD_LE:  simple_res = {{(DW-1){1'b0}}, ($signed(opa) <= $signed(opb))};
			CMD_SHR: simple_res = $signed(opa) >>> amt;
			CMD_SHL: simple_res = opa << amt;
			// Divide, modulo and unused codes pass the left operand; a zero divisor
			// leaves it as the final answer.
			default: simple_res = opa;
		endcase
	end

	always_comb begin
		is_divmod = (cmd == CMD_DIV) || (cmd == CMD_MOD);
		div_zero  = (opb == '0);
		word_in.err     = is_divmod && div_zero;
		word_in.sel_div = (cmd == CMD_DIV) && !div_zero;
		word_in.sel_mod = (cmd == CMD_MOD) && !div_zero;
		word_in.q_neg   = opa[DW-1] ^ opb[DW-1];
		word_in.r_neg   = opa[DW-1];
		word_in.res     = simple_res;
		word_in.rem     = '0;
		// Magnitudes; the minimum value maps onto its own unsigned pattern.
		word_in.dq      = opa[DW-1] ? (~opa + 1'b1) : opa;
		word_in.dvs     = opb[DW-1] ? (~opb + 1'b1) : opb;
	end

	logic      valid_s1;
	div_word_t word_s1;

	// Stage enables: a stage loads when it is empty or its successor loads too.
	logic            en_s1;
	logic            en_out;
	logic [DW-1:0]   dv_en;
	logic [DW-1:0]   dv_valid;
	div_word_t       dv_word [DW];

	assign en_out   = !m_tvalid || m_tready;
	assign en_s1    = !valid_s1 || dv_en[0];
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			word_s1 <= word_in;
		end
	end

	// Stages 2 to 33: one quotient bit per stage.
	for (genvar i = 0; i < DW; i++) begin : g_div
		if (i == DW - 1) begin : g_last
			assign dv_en[i] = !dv_valid[i] || en_out;
		end else begin : g_mid
			assign dv_en[i] = !dv_valid[i] || dv_en[i+1];
		end

		if (i == 0) begin : g_first
			sia_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (dv_en[i]),
				.in_valid  (valid_s1),
				.in_word   (word_s1),
				.out_valid (dv_valid[i]),
				.out_word  (dv_word[i])
			);
		end else begin : g_next
			sia_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (dv_en[i]),
				.in_valid  (dv_valid[i-1]),
				.in_word   (dv_word[i-1]),
				.out_valid (dv_valid[i]),
				.out_word  (dv_word[i])
			);
		end
	end

	// Stage 34: apply signs to quotient or remainder and pick the answer.
	div_word_t     fin;
	logic [DW-1:0] fin_res;
	logic          fin_divmod;

	assign fin        = dv_word[DW-1];
	assign fin_divmod = dv_valid[DW-1] && (fin.sel_div || fin.sel_mod);

	always_comb begin
		if (fin.sel_div) begin
			fin_res = fin.q_neg ? (~fin.dq + 1'b1) : fin.dq;
		end else if (fin.sel_mod) begin
			fin_res = fin.r_neg ? (~fin.rem + 1'b1) : fin.rem;
		end else begin
			fin_res = fin.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_out) begin
			m_tvalid <= dv_valid[DW-1];
		end
	end

	// Hold the word while the consumer stalls.
	always_ff @(posedge clk) begin
		if (en_out) begin
			m_tdata <= {{(OUT_W-DW-1){1'b0}}, fin.err, fin_res};
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPLY(a_stall_only_when_blocked, !s_tready, m_tvalid && !m_tready, "input stalled")
	`ASSERT_NEXT(a_accept_lands_s1, s_tvalid && s_tready, valid_s1, "accepted word lost")
	`ASSERT_IMPLY(a_err_zero_divisor, valid_s1 && word_s1.err, word_s1.dvs == '0, "bad error flag")
	`ASSERT_IMPLY(a_rem_below_divisor, fin_divmod, fin.rem < fin.dvs, "remainder not below divisor")

endmodule

FILE: src/sia_div_stage.sv
module sia_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  sia_pkg::div_word_t in_word,
	output logic               out_valid,
	output sia_pkg::div_word_t out_word
);
	import sia_pkg::*;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        take;
	div_word_t   nxt;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial = {in_word.rem, in_word.dq[DW-1]};
		diff  = trial - {1'b0, in_word.dvs};
		take  = ~diff[DW];
		nxt   = in_word;
		nxt.rem = take ? diff[DW-1:0] : trial[DW-1:0];
		nxt.dq  = {in_word.dq[DW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sia_pkg::*;

	localparam int          RANDOM_WORDS   = 500;
	localparam int          LONG_HOLD      = 300;   // receiver hold-off, well past the pipe depth
	localparam int          BACKLOG_BURST  = 150;   // words offered back to back during the hold
	localparam int          SETTLE_CYCLES  = 40;    // settle time, longer than the pipe latency
	localparam int          STALL_LIMIT    = 2000;  // cycles without any handshake
	localparam logic [DW-1:0] MIN_VAL      = 32'h8000_0000;
	localparam logic [DW-1:0] MAX_VAL      = 32'h7fff_ffff;
	localparam logic [DW-1:0] ALL_ONES     = 32'hffff_ffff;

	// One predicted output word, with the command that caused it kept for reporting.
	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic [DW-1:0]    lhs;
		logic [DW-1:0]    rhs;
		logic [DW-1:0]    value;
		logic             error;
	} alu_outcome_t;

	// Predicts each ALU outcome as words go in and matches them against words coming out.
	class alu_outcome_book;
		alu_outcome_t awaited[$];
		int           mismatches;

		function alu_outcome_t compute(logic [CMD_W-1:0] code, logic signed [DW-1:0] a,
				logic signed [DW-1:0] b);
			alu_outcome_t o;
			logic [DW-1:0] mag_a;
			logic [DW-1:0] mag_b;
			logic [DW-1:0] q;
			o.code  = code;
			o.lhs   = a;
			o.rhs   = b;
			o.value = a;
			o.error = 1'b0;
			// Work on magnitudes; the minimum value maps onto 2**31 as unsigned.
			mag_a = a[DW-1] ? -a : a;
			mag_b = b[DW-1] ? -b : b;
			case (code)
				CMD_SET: o.value = b;
				CMD_ADD: o.value = a + b;
				CMD_SUB: o.value = a - b;
				CMD_MUL: o.value = a * b;
				CMD_DIV, CMD_MOD: begin
					if (b == 0) begin
						o.error = 1'b1;
					end else if (code == CMD_DIV) begin
						q = mag_a / mag_b;
						o.value = (a[DW-1] ^ b[DW-1]) ? -q : q;
					end else begin
						q = mag_a % mag_b;
						o.value = a[DW-1] ? -q : q;
					end
				end
				CMD_AND: o.value = a & b;
				CMD_OR:  o.value = a | b;
				CMD_XOR: o.value = a ^ b;
				CMD_EQ:  o.value = (a == b) ? 1 : 0;
				CMD_NE:  o.value = (a != b) ? 1 : 0;
				CMD_GT:  o.value = (a > b) ? 1 : 0;
				CMD_LT:  o.value = (a < b) ? 1 : 0;
				CMD_GE:  o.value = (a >= b) ? 1 : 0;
				CMD_LE:  o.value = (a <= b) ? 1 : 0;
				CMD_SHR: o.value = a >>> b[SHAMT_W-1:0];
				CMD_SHL: o.value = a << b[SHAMT_W-1:0];
				default: o.value = a;
			endcase
			return o;
		endfunction

		function void note_command(logic [CMD_W-1:0] code, logic [DW-1:0] a, logic [DW-1:0] b);
			awaited.push_back(compute(code, a, b));
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			alu_outcome_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected output word %h", $time, word);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (word[DW-1:0] !== want.value) begin
				$display("%0t: cmd %0d (%0d, %0d) result_value expected %0d actual %0d",
					$time, want.code, $signed(want.lhs), $signed(want.rhs),
					$signed(want.value), $signed(word[DW-1:0]));
				mismatches++;
			end
			if (word[DW] !== want.error) begin
				$display("%0t: cmd %0d (%0d, %0d) error_code expected %0b actual %0b",
					$time, want.code, $signed(want.lhs), $signed(want.rhs),
					want.error, word[DW]);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	alu_outcome_book  book = new();
	bit               receiver_hold = 1'b0;  // raised by the sender, dropped by the receiver

	signed_int32_alu_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Sample both handshakes at the rising edge: predict on the way in, check on the way out.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			book.note_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W+DW-1:CMD_W],
				s_tdata[CMD_W+2*DW-1:CMD_W+DW]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			book.check_result(m_tdata);
		end
	end

	// Offer one word from the falling edge and hold it until the block takes it.
	// Leave s_tvalid high on return so back-to-back words need no extra assignment.
	task automatic send_command(input logic [CMD_W-1:0] code, input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - CMD_W - 2*DW){1'b0}}, b, a, code};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid for a number of cycles and scribble on the bus while idle.
	task automatic idle_for(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= IN_W'({$urandom(), $urandom(), $urandom()});
		end
	endtask

	// Hold the sender off until every predicted word has come back.
	task automatic wait_for_drain();
		do idle_for(1); while (book.awaited.size() != 0);
	endtask

	// Bias operands toward the corners: extremes, zero, one, minus one, small values.
	function automatic logic [DW-1:0] pick_operand();
		logic [DW-1:0] v;
		case ($urandom_range(0, 11))
			0: v = MIN_VAL;
			1: v = MAX_VAL;
			2: v = ALL_ONES;
			3: v = '0;
			4: v = 32'd1;
			5, 6: v = DW'($urandom_range(0, 511)) - 32'd256;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// Mostly legal commands; now and then an unused code, which must pass the left side through.
	function automatic logic [CMD_W-1:0] pick_command();
		if ($urandom_range(0, 29) == 0)
			return CMD_W'($urandom_range(CMD_SHL + 1, 31));
		return CMD_W'($urandom_range(CMD_SET, CMD_SHL));
	endfunction

	task automatic send_random();
		logic [CMD_W-1:0] code;
		logic [DW-1:0]    a;
		logic [DW-1:0]    b;
		code = pick_command();
		a    = pick_operand();
		// Force equal operands now and then so the comparisons see ties.
		b    = ($urandom_range(0, 7) == 0) ? a : pick_operand();
		send_command(code, a, b);
	endtask

	task automatic run_directed();
		send_command(CMD_SET, 32'h1234_5678, MAX_VAL);
		send_command(CMD_ADD, MAX_VAL, 32'd1);            // wrap to the minimum
		send_command(CMD_SUB, MIN_VAL, 32'd1);            // wrap to the maximum
		send_command(CMD_MUL, MIN_VAL, ALL_ONES);         // product wraps back to the minimum
		send_command(CMD_MUL, MAX_VAL, MAX_VAL);
		send_command(CMD_DIV, 32'd7, -32'sd2);            // truncates toward zero
		send_command(CMD_MOD, -32'sd7, 32'd2);            // remainder follows the dividend
		send_command(CMD_DIV, MAX_VAL, '0);               // zero divisor
		send_command(CMD_MOD, MIN_VAL, '0);
		send_command(CMD_DIV, MIN_VAL, ALL_ONES);         // minimum over minus one
		send_command(CMD_MOD, MIN_VAL, ALL_ONES);
		send_command(CMD_AND, 32'hf0f0_a5a5, 32'h0ff0_ffff);
		send_command(CMD_OR,  32'h8000_0001, 32'h0000_fff0);
		send_command(CMD_XOR, ALL_ONES, 32'h5a5a_5a5a);
		send_command(CMD_EQ,  MIN_VAL, MIN_VAL);
		send_command(CMD_NE,  MIN_VAL, MAX_VAL);
		send_command(CMD_GT,  MIN_VAL, MAX_VAL);          // signed, not unsigned, ordering
		send_command(CMD_LT,  MIN_VAL, MAX_VAL);
		send_command(CMD_GE,  ALL_ONES, ALL_ONES);
		send_command(CMD_LE,  MAX_VAL, ALL_ONES);
		send_command(CMD_SHR, MIN_VAL, 32'd31);           // sign fill all the way
		send_command(CMD_SHR, -32'sd100, 32'd33);         // only the low five bits count
		send_command(CMD_SHL, ALL_ONES, 32'd31);
		send_command(CMD_SHL, 32'h0000_00ff, 32'hffff_ffe0); // amount field is zero
		send_command(CMD_W'(17), MAX_VAL, 32'd5);         // unused codes pass the left side
		send_command(CMD_W'(31), MIN_VAL, ALL_ONES);
	endtask

	// Receiver: stall in spans of varying style; honor one long hold-off on request.
	initial begin : receiver
		int span;
		int style;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold) begin
				repeat (LONG_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				receiver_hold = 1'b0;
			end
			style = $urandom_range(0, 3);
			span  = $urandom_range(1, 40);
			repeat (span) begin
				@(negedge clk);
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int  sent;
		int  burst;
		bit  hold_started;
		bit  drained_once;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		wait_for_drain();

		sent         = 0;
		hold_started = 1'b0;
		drained_once = 1'b0;
		while (sent < RANDOM_WORDS) begin
			// Once past the first couple hundred words, freeze the receiver and keep offering
			// words so the pipe fills and s_tready drops.
			if (!hold_started && sent >= 200) begin
				hold_started  = 1'b1;
				receiver_hold = 1'b1;
				burst         = BACKLOG_BURST;
			end else begin
				burst = $urandom_range(1, 30);
			end
			repeat (burst) begin
				send_random();
				sent++;
			end
			// Pause once with the pipe fully empty; otherwise leave a random gap, often none.
			if (!drained_once && sent >= 380) begin
				drained_once = 1'b1;
				wait_for_drain();
			end else if ($urandom_range(0, 2) != 0) begin
				idle_for($urandom_range(1, 12));
			end
		end
		idle_for(1);

		// Wait out the tail, then give any stray word a chance to show up.
		while (book.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (book.mismatches == 0 && book.awaited.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/sia_pkg.sv
src/sia_div_stage.sv
src/signed_int32_alu_unit.sv
dv/testbench.sv
